FILE: src/mfst_pkg.sv
// Package with the shared types and constants of the mode finder.
`default_nettype none

package mfst_pkg;

    localparam int LIST_DEPTH = 256;
    localparam int PRICE_BITS = 32;
    localparam int IDX_BITS   = $clog2(LIST_DEPTH);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int PCT_BITS   = 7;
    localparam int DVD_BITS   = CNT_BITS + PCT_BITS;
    localparam int STEP_BITS  = $clog2(DVD_BITS + 1);

    typedef logic [PRICE_BITS-1:0] price_t;
    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;
    typedef logic [PCT_BITS-1:0]   pct_t;
    typedef logic [DVD_BITS-1:0]   dvd_t;
    typedef logic [STEP_BITS-1:0]  step_t;

    localparam dvd_t PCT_SCALE = dvd_t'(100);

    typedef struct packed {
        logic start;
        dvd_t dividend;
        cnt_t divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        pct_t quotient;
    } div_stat_t;

endpackage

`default_nettype wire

FILE: src/mfst_if.sv
// Valid/ready channel interfaces for the list items and the result items.
`default_nettype none

interface mfst_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] price;
    logic        last;

    modport source (output valid, output price, output last, input ready);
    modport sink   (input valid, input price, input last, output ready);
endinterface

interface mfst_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] mode_value;
    logic [8:0]  occurrences;
    logic [6:0]  share_percent;
    logic        truncated;

    modport source (output valid, output mode_value, output occurrences,
                    output share_percent, output truncated, input ready);
    modport sink   (input valid, input mode_value, input occurrences,
                    input share_percent, input truncated, output ready);
endinterface

`default_nettype wire

FILE: src/mode_finder_smallest_tie_top.sv
// Top level of the mode finder: list loading, counting sequencer and result register.
// A value that does not close the list is taken without stalling the input.
// A closing value is answered once the count sweep and the percentage divide have finished:
// one shared equality compare sweeps the store once per stored value, one read per cycle.
// The input is not ready from the closing value until the result is in the output register.
// Reset clears all control state; the store contents stay undefined and need no clearing.
`default_nettype none

module mode_finder_smallest_tie_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mfst_in_if.sink     din,
    mfst_out_if.source  dout
);
    import mfst_pkg::*;

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_FETCH = 7'b0000010,
        S_LATCH = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_UPD   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    cnt_t   fill_reg, fill_next;
    logic   ovf_reg, ovf_next;
    cnt_t   i_reg, i_next;
    cnt_t   j_reg, j_next;
    logic   pend_reg, pend_next;
    cnt_t   cnt_reg, cnt_next;
    price_t cur_reg, cur_next;
    price_t best_val_reg, best_val_next;
    cnt_t   best_cnt_reg, best_cnt_next;
    logic   div_start_reg, div_start_next;
    logic   out_valid_reg, out_valid_next;
    price_t out_val_reg, out_val_next;
    cnt_t   out_cnt_reg, out_cnt_next;
    pct_t   out_pct_reg, out_pct_next;
    logic   out_trunc_reg, out_trunc_next;

    logic      accept;
    logic      wr_en;
    idx_t      rd_addr;
    price_t    rd_data;
    div_req_t  div_req;
    div_stat_t div_stat;

    mfst_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[IDX_BITS-1:0]),
        .wr_data (din.price),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mfst_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    assign din.ready = (state_reg == S_LOAD);
    assign accept    = din.valid && din.ready;
    assign wr_en     = accept && (fill_reg < cnt_t'(LIST_DEPTH));
    assign rd_addr   = (state_reg == S_FETCH) ? i_reg[IDX_BITS-1:0] : j_reg[IDX_BITS-1:0];

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = dvd_t'(best_cnt_reg) * PCT_SCALE;
    assign div_req.divisor  = fill_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        pend_next      = pend_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        best_val_next  = best_val_reg;
        best_cnt_next  = best_cnt_reg;
        div_start_next = 1'b0;
        out_valid_next = out_valid_reg;
        out_val_next   = out_val_reg;
        out_cnt_next   = out_cnt_reg;
        out_pct_next   = out_pct_reg;
        out_trunc_next = out_trunc_reg;

        if (out_valid_reg && dout.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (wr_en)
                    begin
                        fill_next = fill_reg + cnt_t'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (din.last)
                    begin
                        i_next        = '0;
                        best_val_next = '0;
                        best_cnt_next = '0;
                        state_next    = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_LATCH;
            end
            S_LATCH:
            begin
                cur_next   = rd_data;
                j_next     = '0;
                cnt_next   = '0;
                pend_next  = 1'b0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (pend_reg && (rd_data == cur_reg))
                begin
                    cnt_next = cnt_reg + cnt_t'(1);
                end
                if (j_reg < fill_reg)
                begin
                    j_next    = j_reg + cnt_t'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if ((cnt_reg > best_cnt_reg) ||
                    ((cnt_reg == best_cnt_reg) && (cur_reg < best_val_reg)))
                begin
                    best_cnt_next = cnt_reg;
                    best_val_next = cur_reg;
                end
                if (i_reg == fill_reg - cnt_t'(1))
                begin
                    div_start_next = 1'b1;
                    state_next     = S_DIV;
                end
                else
                begin
                    i_next     = i_reg + cnt_t'(1);
                    state_next = S_FETCH;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || dout.ready)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = best_val_reg;
                    out_cnt_next   = best_cnt_reg;
                    out_pct_next   = div_stat.quotient;
                    out_trunc_next = ovf_reg;
                    fill_next      = '0;
                    ovf_next       = 1'b0;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            pend_reg      <= 1'b0;
            cnt_reg       <= '0;
            best_val_reg  <= '0;
            best_cnt_reg  <= '0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            best_val_reg  <= best_val_next;
            best_cnt_reg  <= best_cnt_next;
            div_start_reg <= div_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        out_val_reg   <= out_val_next;
        out_cnt_reg   <= out_cnt_next;
        out_pct_reg   <= out_pct_next;
        out_trunc_reg <= out_trunc_next;
    end

    assign dout.valid         = out_valid_reg;
    assign dout.mode_value    = out_val_reg;
    assign dout.occurrences   = out_cnt_reg;
    assign dout.share_percent = out_pct_reg;
    assign dout.truncated     = out_trunc_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= cnt_t'(LIST_DEPTH))
        else $error("Fill count exceeds the store depth.");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("Divider finished outside the divide state.");

    a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (i_reg < fill_reg) && (j_reg <= fill_reg))
        else $error("Scan indexes run past the stored length.");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("Result item appeared without a finished count.");

endmodule

`default_nettype wire

FILE: src/mfst_store.sv
// Value store: one write port and one registered read port.
`default_nettype none

module mfst_store (
    input  wire logic           clk,
    input  wire logic           wr_en,
    input  wire mfst_pkg::idx_t  wr_addr,
    input  wire mfst_pkg::price_t wr_data,
    input  wire mfst_pkg::idx_t  rd_addr,
    output mfst_pkg::price_t     rd_data
);
    import mfst_pkg::*;

    price_t mem [LIST_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: src/mfst_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module mfst_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mfst_pkg::div_req_t req,
    output mfst_pkg::div_stat_t    stat
);
    import mfst_pkg::*;

    logic  busy_reg, busy_next;
    logic  done_reg, done_next;
    step_t step_reg, step_next;
    cnt_t  rem_reg, rem_next;
    dvd_t  quo_reg, quo_next;
    cnt_t  dsr_reg, dsr_next;

    logic [CNT_BITS:0] shifted;
    logic [CNT_BITS:0] diff;
    logic              fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DVD_BITS-1]};
        diff    = shifted - {1'b0, dsr_reg};
        fits    = shifted >= {1'b0, dsr_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = step_t'(DVD_BITS);
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[CNT_BITS-1:0] : shifted[CNT_BITS-1:0];
            quo_next  = {quo_reg[DVD_BITS-2:0], fits};
            step_next = step_reg - step_t'(1);
            if (step_reg == step_t'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg[PCT_BITS-1:0];

endmodule

`default_nettype wire

FILE: tb/mode_finder_smallest_tie_top_tb.sv
// Self-checking testbench for the mode finder: directed lists, then random lists and full stores.
module mode_finder_smallest_tie_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mfst_pkg::*;

    typedef struct packed {
        price_t mode;
        cnt_t   occ;
        pct_t   pct;
        logic   trunc;
    } mode_report_t;

    typedef struct packed {
        price_t       price;
        logic         last;
        logic         typed;
        mode_report_t want;
    } list_row_t;

    localparam int DIRECTED_ROWS = 22;
    localparam int RANDOM_ITEMS  = 728;

    localparam list_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 9'd1, 7'd100, 1'b0}},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 9'd1, 7'd100, 1'b0}},
        '{32'd5, 1'b0, 1'b0, '0},
        '{32'd3, 1'b1, 1'b0, '0},
        '{32'd7, 1'b0, 1'b0, '0},
        '{32'd7, 1'b0, 1'b0, '0},
        '{32'd2, 1'b1, 1'b0, '0},
        '{32'd9, 1'b0, 1'b0, '0},
        '{32'd4, 1'b0, 1'b0, '0},
        '{32'd9, 1'b0, 1'b0, '0},
        '{32'd4, 1'b0, 1'b0, '0},
        '{32'd1, 1'b1, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b1, 1'b0, '0},
        '{32'h0000_000A, 1'b0, 1'b0, '0},
        '{32'h8000_0000, 1'b0, 1'b0, '0},
        '{32'h8000_0000, 1'b0, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b1, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    mfst_in_if  in_ch ();
    mfst_out_if out_ch ();

    mode_finder_smallest_tie_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (in_ch),
        .dout  (out_ch)
    );

    always #6 clk = ~clk;

    price_t       list_prices [$];
    logic         list_dropped = 1'b0;
    mode_report_t mode_reports_due [$];
    int           mismatch_count = 0;
    int           idle_pct = 0;
    int           stall_pct = 0;

    function automatic bit tally_price(input price_t p, input logic l,
                                       output mode_report_t r);
        int     n;
        int     c;
        int     best_c;
        price_t best_v;
        r = '0;
        if (list_prices.size() < LIST_DEPTH)
            list_prices.push_back(p);
        else
            list_dropped = 1'b1;
        if (!l)
            return 1'b0;
        n = list_prices.size();
        best_c = 0;
        best_v = '0;
        for (int i = 0; i < n; i++)
        begin
            c = 0;
            for (int j = 0; j < n; j++)
                if (list_prices[j] == list_prices[i])
                    c++;
            if (c > best_c || (c == best_c && list_prices[i] < best_v))
            begin
                best_c = c;
                best_v = list_prices[i];
            end
        end
        r.mode  = best_v;
        r.occ   = cnt_t'(best_c);
        r.pct   = pct_t'((best_c * 100) / n);
        r.trunc = list_dropped;
        list_prices.delete();
        list_dropped = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_price(input price_t p, input logic l, input logic typed,
                              input mode_report_t want);
        mode_report_t got;
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.price <= p;
        in_ch.last  <= l;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (tally_price(p, l, got))
            mode_reports_due.push_back(typed ? want : got);
    endtask

    task automatic set_idling(input int phase);
        case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 54; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 54; end
            default: begin idle_pct = 29; stall_pct = 29; end
        endcase
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (mode_reports_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0d ns: %s expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        mode_report_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (mode_reports_due.size() == 0)
            begin
                $display("%0d ns: unexpected result, actual mode %0h count %0d share %0d trunc %0b",
                         $time, out_ch.mode_value, out_ch.occurrences,
                         out_ch.share_percent, out_ch.truncated);
                mismatch_count++;
            end
            else
            begin
                want = mode_reports_due.pop_front();
                check_field("mode_value", want.mode, out_ch.mode_value);
                check_field("occurrences", want.occ, out_ch.occurrences);
                check_field("share_percent", want.pct, out_ch.share_percent);
                check_field("truncated", want.trunc, out_ch.truncated);
            end
        end
    end

    initial
    begin
        int     sent;
        int     list_no;
        int     len;
        int     pool_n;
        price_t pool [4];
        price_t p;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.price <= '0;
        in_ch.last  <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[k])
            send_price(DIRECTED[k].price, DIRECTED[k].last, DIRECTED[k].typed,
                       DIRECTED[k].want);
        drain_results();

        sent = 0;
        list_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            set_idling((list_no / 3) % 4);
            if (list_no == 8)
            begin
                drain_results();
                p = $urandom;
                for (int k = 0; k < LIST_DEPTH; k++)
                    send_price(p, k == LIST_DEPTH - 1, 1'b0, '0);
                sent += LIST_DEPTH;
            end
            else
            begin
                pool_n = $urandom_range(1, 4);
                for (int k = 0; k < pool_n; k++)
                    case ($urandom_range(3))
                        0:       pool[k] = price_t'($urandom_range(15));
                        1:       pool[k] = 32'hFFFF_FFF0 | price_t'($urandom_range(15));
                        default: pool[k] = $urandom;
                    endcase
                if (list_no == 20)
                    len = LIST_DEPTH + 4;
                else if ($urandom_range(9) == 0)
                    len = $urandom_range(13, 40);
                else
                    len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                begin
                    p = ($urandom_range(4) == 0) ? price_t'($urandom)
                                                 : pool[$urandom_range(pool_n - 1)];
                    send_price(p, k == len - 1, 1'b0, '0);
                end
                sent += len;
            end
            list_no++;
        end

        drain_results();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
